// ----- rtl/vbtg_pkg.sv -----
// Shared types, register codes and constants for the vario beep tone generator.
`default_nettype none

package vbtg_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int SINE_DEPTH_DEF = 256;
    localparam int CFG_ADDR_W     = 5;
    localparam int CFG_DATA_W     = 32;

    localparam logic [14:0] S16_FULL = 15'h7FFF;
    localparam logic [15:0] U8_MID   = 16'd127;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_UPPER = 2'd1,
        MODE_LOWER = 2'd2
    } t_sound_mode;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_SAW      = 2'd3
    } t_wave_shape;

    typedef enum logic {
        FMT_U8  = 1'b0,
        FMT_S16 = 1'b1
    } t_sample_fmt;

    typedef enum logic [2:0] {
        REG_UPPER_ON      = 3'd0,
        REG_UPPER_OFF     = 3'd1,
        REG_LOWER_ON      = 3'd2,
        REG_LOWER_OFF     = 3'd3,
        REG_WAVE_SHAPE    = 3'd4,
        REG_SAMPLE_FORMAT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] upper_on_level;
        logic signed [15:0] upper_off_level;
        logic signed [15:0] lower_on_level;
        logic signed [15:0] lower_off_level;
        t_wave_shape        wave_shape;
        t_sample_fmt        sample_format;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/vbtg_in_if.sv -----
// Input channel: climb value updates and sample ticks.
`default_nettype none

interface vbtg_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] climb_value;
    logic [14:0]        tone_step;
    logic [15:0]        cycle_step;
    logic [16:0]        duty_level;

    modport source (
        output valid, opcode, climb_value, tone_step, cycle_step, duty_level,
        input  ready
    );
    modport sink (
        input  valid, opcode, climb_value, tone_step, cycle_step, duty_level,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/vbtg_out_if.sv -----
// Output channel: audio samples with the sound mode in force.
`default_nettype none

interface vbtg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic [1:0]         sound_mode;

    modport source (
        output valid, sample_out, sound_mode,
        input  ready
    );
    modport sink (
        input  valid, sample_out, sound_mode,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/vbtg_cfg_regs.sv -----
// APB configuration registers: hysteresis levels, wave shape and sample format.
`default_nettype none

module vbtg_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vbtg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [vbtg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [vbtg_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output vbtg_pkg::t_cfg                      o_cfg
);
    import vbtg_pkg::*;

    logic signed [15:0] r_upper_on;
    logic signed [15:0] r_upper_off;
    logic signed [15:0] r_lower_on;
    logic signed [15:0] r_lower_off;
    t_wave_shape        r_shape;
    t_sample_fmt        r_fmt;
    logic               wr_en;
    logic [2:0]         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_on  <= 16'sd256;
            r_upper_off <= 16'sd128;
            r_lower_on  <= -16'sd512;
            r_lower_off <= -16'sd384;
            r_shape     <= SHAPE_SINE;
            r_fmt       <= FMT_S16;
        end else if (wr_en) begin
            case (reg_sel)
                REG_UPPER_ON:      r_upper_on  <= pwdata[15:0];
                REG_UPPER_OFF:     r_upper_off <= pwdata[15:0];
                REG_LOWER_ON:      r_lower_on  <= pwdata[15:0];
                REG_LOWER_OFF:     r_lower_off <= pwdata[15:0];
                REG_WAVE_SHAPE:    r_shape     <= t_wave_shape'(pwdata[1:0]);
                REG_SAMPLE_FORMAT: r_fmt       <= t_sample_fmt'(pwdata[0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_UPPER_ON:      prdata = {16'd0, r_upper_on};
            REG_UPPER_OFF:     prdata = {16'd0, r_upper_off};
            REG_LOWER_ON:      prdata = {16'd0, r_lower_on};
            REG_LOWER_OFF:     prdata = {16'd0, r_lower_off};
            REG_WAVE_SHAPE:    prdata = {30'd0, r_shape};
            REG_SAMPLE_FORMAT: prdata = {31'd0, r_fmt};
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.upper_on_level  = r_upper_on;
        o_cfg.upper_off_level = r_upper_off;
        o_cfg.lower_on_level  = r_lower_on;
        o_cfg.lower_off_level = r_lower_off;
        o_cfg.wave_shape      = r_shape;
        o_cfg.sample_format   = r_fmt;
    end

endmodule

`default_nettype wire

// ----- rtl/vbtg_mode.sv -----
// Hysteresis state machine for the sound mode, driven by climb value updates.
`default_nettype none

module vbtg_mode (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_upd,
    input  logic signed [15:0]     i_climb,
    input  vbtg_pkg::t_cfg         i_cfg,
    output vbtg_pkg::t_sound_mode  o_mode
);
    import vbtg_pkg::*;

    t_sound_mode        r_mode;
    t_sound_mode        n_mode;
    logic signed [15:0] r_last;
    logic               r_have;
    logic               take;

    // A repeat of the last value changes nothing.
    assign take = i_upd && !(r_have && (i_climb == r_last));

    always_comb begin
        n_mode = r_mode;
        if (take) begin
            if (!r_have) begin
                if (i_climb >= i_cfg.upper_on_level) begin
                    n_mode = MODE_UPPER;
                end else if (i_climb <= i_cfg.lower_on_level) begin
                    n_mode = MODE_LOWER;
                end
            end else if (i_climb > r_last) begin
                // rising: leave lower first, then maybe enter upper
                if (n_mode == MODE_LOWER && i_climb >= i_cfg.lower_off_level) begin
                    n_mode = MODE_OFF;
                end
                if (n_mode == MODE_OFF && i_climb >= i_cfg.upper_on_level) begin
                    n_mode = MODE_UPPER;
                end
            end else begin
                if (n_mode == MODE_UPPER && i_climb <= i_cfg.upper_off_level) begin
                    n_mode = MODE_OFF;
                end
                if (n_mode == MODE_OFF && i_climb <= i_cfg.lower_on_level) begin
                    n_mode = MODE_LOWER;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
            r_have <= 1'b0;
            r_last <= '0;
        end else if (take) begin
            r_mode <= n_mode;
            r_have <= 1'b1;
            r_last <= i_climb;
        end
    end

    always_comb begin
        case (r_mode)
            MODE_UPPER: o_mode = MODE_UPPER;
            MODE_LOWER: o_mode = MODE_LOWER;
            default:    o_mode = MODE_OFF;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/vbtg_wave.sv -----
// Waveform sample from the top 16 tone phase bits: sine, square, triangle, sawtooth.
`default_nettype none

module vbtg_wave #(
    parameter int SINE_TABLE_DEPTH = vbtg_pkg::SINE_DEPTH_DEF
) (
    input  logic [15:0]             i_phase,
    input  vbtg_pkg::t_wave_shape   i_shape,
    input  vbtg_pkg::t_sample_fmt   i_fmt,
    output logic signed [15:0]      o_sample
);
    import vbtg_pkg::*;

    localparam int          IW     = $clog2(SINE_TABLE_DEPTH);
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef logic [14:0] t_rom [SINE_TABLE_DEPTH];

    // Quarter-wave sine in Q30 by a Taylor series to x^11, scaled to 32767.
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] e;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            x  = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            d  = ((x2 * t) >> 30) / 64'd110;
            t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
            d  = ((x2 * t) >> 30) / 64'd72;
            t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
            d  = ((x2 * t) >> 30) / 64'd42;
            t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
            d  = ((x2 * t) >> 30) / 64'd20;
            t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
            d  = ((x2 * t) >> 30) / 64'd6;
            t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
            s  = (x * t) >> 30;
            e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            rom[i] = (e > 64'd32767) ? S16_FULL : e[14:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [1:0]    quad;
    logic [IW+14:0] idx_prod;
    logic [IW-1:0] idx;
    logic [IW:0]   mir_full;
    logic [IW-1:0] rom_idx;
    logic [14:0]   sine_m;
    logic [15:0]   mag;
    logic          neg;
    logic [14:0]   scale;
    logic [30:0]   prod;
    logic [6:0]    sq0;
    logic [15:0]   rem_sum;
    logic [15:0]   sine_q;
    logic [15:0]   sine_rem;
    logic [15:0]   q;
    logic          inexact;
    logic [15:0]   result;

    always_comb begin
        quad     = i_phase[15:14];
        idx_prod = (IW+15)'(i_phase[13:0]) * (IW+15)'(SINE_TABLE_DEPTH);
        idx      = idx_prod[IW+13:14];
        mir_full = (IW+1)'(SINE_TABLE_DEPTH) - {1'b0, idx};
        // odd quadrants run the table backwards; the mirror point is full scale
        rom_idx  = quad[0] ? mir_full[IW-1:0] : idx;
        sine_m   = (quad[0] && (idx == '0)) ? S16_FULL : SINE_ROM[rom_idx];
    end

    always_comb begin
        case (i_shape)
            SHAPE_SINE: begin
                mag = {1'b0, sine_m};
                neg = quad[1];
            end
            SHAPE_SQUARE: begin
                mag = 16'd1;
                neg = i_phase[15];
            end
            SHAPE_TRIANGLE: begin
                if (i_phase < 16'd16384) begin
                    mag = i_phase;
                    neg = 1'b0;
                end else if (i_phase <= 16'd32768) begin
                    mag = 16'd32768 - i_phase;
                    neg = 1'b0;
                end else if (i_phase < 16'd49152) begin
                    mag = i_phase - 16'd32768;
                    neg = 1'b1;
                end else begin
                    mag = 16'(17'h10000 - {1'b0, i_phase});
                    neg = 1'b1;
                end
            end
            SHAPE_SAW: begin
                if (!i_phase[15]) begin
                    mag = i_phase;
                    neg = 1'b0;
                end else begin
                    mag = 16'(17'h10000 - {1'b0, i_phase});
                    neg = 1'b1;
                end
            end
            default: begin
                mag = '0;
                neg = 1'b0;
            end
        endcase
    end

    always_comb begin
        scale = (i_fmt == FMT_S16) ? S16_FULL : U8_MID[14:0];
        prod  = 31'(mag) * 31'(scale);

        // floor(m*127 / 32767): take off by 2^15, fold the quotient back in
        sq0     = prod[21:15];
        rem_sum = 16'(prod[14:0]) + 16'(sq0);
        if (rem_sum >= 16'd32767) begin
            sine_q   = 16'(sq0) + 16'd1;
            sine_rem = rem_sum - 16'd32767;
        end else begin
            sine_q   = 16'(sq0);
            sine_rem = rem_sum;
        end

        case (i_shape)
            SHAPE_SINE: begin
                q       = (i_fmt == FMT_S16) ? mag : sine_q;
                inexact = (i_fmt == FMT_U8) && (sine_rem != '0);
            end
            SHAPE_SQUARE: begin
                q       = (i_fmt == FMT_S16) ? 16'(S16_FULL) : U8_MID;
                inexact = 1'b0;
            end
            SHAPE_TRIANGLE: begin
                q       = 16'(prod >> 14);
                inexact = |prod[13:0];
            end
            SHAPE_SAW: begin
                q       = 16'(prod >> 15);
                inexact = |prod[14:0];
            end
            default: begin
                q       = '0;
                inexact = 1'b0;
            end
        endcase

        // 16-bit truncates toward zero; 8-bit floors around the midpoint
        if (i_fmt == FMT_S16) begin
            result = neg ? (16'd0 - q) : q;
        end else begin
            result = neg ? (U8_MID - q - 16'(inexact)) : (U8_MID + q);
        end
        o_sample = $signed(result);
    end

endmodule

`default_nettype wire

// ----- rtl/vario_beep_tone_generator_core.sv -----
// Top level: input register, beep and tone phase accumulators, output register.
//
//  channel   direction  handshake          payload
//  i_in      in         valid / ready      opcode, climb_value, tone_step,
//                                          cycle_step, duty_level
//  o_out     out        valid / ready      sample_out, sound_mode
//  cfg (APB) in         psel/penable/...   six registers at 4*i, 32-bit data
//
// One item per cycle sustained while the output register is not held; a tick's
// sample passes the input register, then the output register. Updates give no result.
// The phase and mode update plus the sine table lookup sit between those registers.
// Reset is synchronous and clears all control state and the accumulators.
// A tick waits in the input register while the output register is held;
// updates pass through regardless of the output side.
`default_nettype none

module vario_beep_tone_generator_core #(
    parameter int PHASE_BITS       = vbtg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = vbtg_pkg::SINE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    vbtg_in_if.sink                             i_in,
    vbtg_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vbtg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [vbtg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [vbtg_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import vbtg_pkg::*;

    t_cfg                  cfg;
    t_sound_mode           mode;

    logic                  r_in_v;
    t_opcode               r_in_op;
    logic signed [15:0]    r_in_climb;
    logic [14:0]           r_in_tone_step;
    logic [15:0]           r_in_cycle_step;
    logic [16:0]           r_in_duty;

    logic [PHASE_BITS-1:0] r_cycle;
    logic [PHASE_BITS-1:0] r_tone;
    logic [PHASE_BITS-1:0] n_cycle;
    logic [PHASE_BITS-1:0] n_tone;

    logic                  r_out_v;
    logic signed [15:0]    r_out_sample;
    t_sound_mode           r_out_mode;
    logic signed [15:0]    n_out_sample;

    logic                  s1_go;
    logic                  tick_go;
    logic                  upd_go;
    logic                  in_take;
    logic [PHASE_BITS+15:0] cyc_top_w;
    logic [PHASE_BITS+15:0] tone_top_w;
    logic [PHASE_BITS+15:0] tone_inc_w;
    logic [PHASE_BITS+15:0] cyc_inc_w;
    logic [15:0]           cyc_top;
    logic [15:0]           tone_top;
    logic                  beep_on;
    logic signed [15:0]    wave_sample;
    logic signed [15:0]    silence;

    vbtg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vbtg_mode u_mode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd_go),
        .i_climb (r_in_climb),
        .i_cfg   (cfg),
        .o_mode  (mode)
    );

    vbtg_wave #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_wave (
        .i_phase  (tone_top),
        .i_shape  (cfg.wave_shape),
        .i_fmt    (cfg.sample_format),
        .o_sample (wave_sample)
    );

    // Updates never need the output register; ticks need it free or draining.
    always_comb begin
        s1_go      = r_in_v && ((r_in_op == OP_UPDATE) || !r_out_v || o_out.ready);
        tick_go    = s1_go && (r_in_op == OP_TICK);
        upd_go     = s1_go && (r_in_op == OP_UPDATE);
        i_in.ready = !r_in_v || s1_go;
        in_take    = i_in.valid && i_in.ready;
    end

    // Align Q0.16 quantities with the phase width in either direction.
    always_comb begin
        cyc_top_w  = {r_cycle, 16'd0} >> PHASE_BITS;
        tone_top_w = {r_tone, 16'd0} >> PHASE_BITS;
        tone_inc_w = {1'b0, r_in_tone_step, {PHASE_BITS{1'b0}}} >> 16;
        cyc_inc_w  = {r_in_cycle_step, {PHASE_BITS{1'b0}}} >> 16;
        cyc_top    = cyc_top_w[15:0];
        tone_top   = tone_top_w[15:0];
        beep_on    = r_in_duty > {1'b0, cyc_top};
        silence    = (cfg.sample_format == FMT_S16) ? 16'sd0 : $signed(U8_MID);
    end

    always_comb begin
        n_out_sample = silence;
        if (mode == MODE_OFF) begin
            n_cycle = '0;
            n_tone  = '0;
        end else begin
            if (beep_on) begin
                n_out_sample = wave_sample;
                n_tone       = r_tone + tone_inc_w[PHASE_BITS-1:0];
            end else begin
                // restart the tone at every beep
                n_tone = '0;
            end
            n_cycle = r_cycle + cyc_inc_w[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= in_take || (r_in_v && !s1_go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op         <= t_opcode'(i_in.opcode);
            r_in_climb      <= i_in.climb_value;
            r_in_tone_step  <= i_in.tone_step;
            r_in_cycle_step <= i_in.cycle_step;
            r_in_duty       <= i_in.duty_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle <= '0;
            r_tone  <= '0;
        end else if (tick_go) begin
            r_cycle <= n_cycle;
            r_tone  <= n_tone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= tick_go || (r_out_v && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_out_sample <= n_out_sample;
            r_out_mode   <= mode;
        end
    end

    always_comb begin
        o_out.valid      = r_out_v;
        o_out.sample_out = r_out_sample;
        o_out.sound_mode = r_out_mode;
    end

endmodule

`default_nettype wire
